### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define KNRR_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define KNRR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the following cycle.
`define KNRR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/knrr_pkg.sv
// ----------------------------------------------------------------------------
// knrr_pkg
// Types, constants and the rank factor table of the recency ranker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package knrr_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int TABLE_SIZE      = 64;
    localparam int SSID_BITS       = 256;

    localparam logic [1:0] CMD_SEEN      = 2'd0;
    localparam logic [1:0] CMD_CONNECTED = 2'd1;
    localparam logic [1:0] CMD_RANK      = 2'd2;
    localparam logic [1:0] KIND_PSK      = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] ssid_word0;
        logic [63:0] ssid_word1;
        logic [63:0] ssid_word2;
        logic [63:0] ssid_word3;
        logic [1:0]  security_type;
        logic [39:0] stored_seconds;
        logic [29:0] stored_nanos;
        logic        storage_ok;
    } in_t;

    typedef struct packed {
        logic        success;
        logic [16:0] rank_modifier;
        logic        evicted;
    } out_t;

    typedef struct packed {
        logic [SSID_BITS-1:0] ssid;
        logic [1:0]           kind;
        logic [39:0]          seconds;
        logic [29:0]          nanos;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_WRITE,
        ST_DONE
    } state_t;

    // round(65536 / n^0.3), n = idx + 1
    function automatic logic [16:0] rank_factor(input logic [5:0] idx);
        logic [16:0] v;
        v = 17'd0;
        unique case (idx)
            6'd0:  v = 17'd65536; 6'd1:  v = 17'd53232; 6'd2:  v = 17'd47135;
            6'd3:  v = 17'd43238; 6'd4:  v = 17'd40438; 6'd5:  v = 17'd38286;
            6'd6:  v = 17'd36555; 6'd7:  v = 17'd35120; 6'd8:  v = 17'd33901;
            6'd9:  v = 17'd32846; 6'd10: v = 17'd31920; 6'd11: v = 17'd31098;
            6'd12: v = 17'd30360; 6'd13: v = 17'd29692; 6'd14: v = 17'd29084;
            6'd15: v = 17'd28526; 6'd16: v = 17'd28012; 6'd17: v = 17'd27536;
            6'd18: v = 17'd27093; 6'd19: v = 17'd26679; 6'd20: v = 17'd26291;
            6'd21: v = 17'd25927; 6'd22: v = 17'd25584; 6'd23: v = 17'd25259;
            6'd24: v = 17'd24952; 6'd25: v = 17'd24660; 6'd26: v = 17'd24382;
            6'd27: v = 17'd24118; 6'd28: v = 17'd23865; 6'd29: v = 17'd23623;
            6'd30: v = 17'd23392; 6'd31: v = 17'd23170; 6'd32: v = 17'd22958;
            6'd33: v = 17'd22753; 6'd34: v = 17'd22556; 6'd35: v = 17'd22366;
            6'd36: v = 17'd22183; 6'd37: v = 17'd22006; 6'd38: v = 17'd21835;
            6'd39: v = 17'd21670; 6'd40: v = 17'd21510; 6'd41: v = 17'd21355;
            6'd42: v = 17'd21205; 6'd43: v = 17'd21059; 6'd44: v = 17'd20918;
            6'd45: v = 17'd20780; 6'd46: v = 17'd20647; 6'd47: v = 17'd20517;
            6'd48: v = 17'd20390; 6'd49: v = 17'd20267; 6'd50: v = 17'd20147;
            6'd51: v = 17'd20030; 6'd52: v = 17'd19916; 6'd53: v = 17'd19804;
            6'd54: v = 17'd19696; 6'd55: v = 17'd19590; 6'd56: v = 17'd19486;
            6'd57: v = 17'd19384; 6'd58: v = 17'd19285; 6'd59: v = 17'd19188;
            6'd60: v = 17'd19093; 6'd61: v = 17'd19000; 6'd62: v = 17'd18909;
            6'd63: v = 17'd18820;
        endcase
        return v;
    endfunction

endpackage

### rtl/knrr_trim.sv
// ----------------------------------------------------------------------------
// knrr_trim
// Cuts an SSID at its first zero byte; later bytes read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module knrr_trim
    import knrr_pkg::*;
(
    input  logic [SSID_BITS-1:0] raw,
    output logic [SSID_BITS-1:0] key
);

    localparam int NB = SSID_BITS / 8;

    logic [NB-1:0] zero_byte;

    always_comb begin
        for (int k = 0; k < NB; k++) begin
            zero_byte[k] = (raw[8*k +: 8] == 8'd0);
        end
        // byte k survives only when no zero byte sits at or before it
        for (int k = 0; k < NB; k++) begin
            key[8*k +: 8] = (|(zero_byte & ((NB'(1) << k) | ((NB'(1) << k) - NB'(1)))))
                            ? 8'd0 : raw[8*k +: 8];
        end
    end

endmodule

### rtl/known_network_recency_ranker_top.sv
// ----------------------------------------------------------------------------
// known_network_recency_ranker_top
// Recency-ordered list of known networks with seen, connected and rank commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one command transaction (seen, connected, rank) per s_data.
//   m_* channel: exactly one result transaction per command, in order.
//   Both use valid/ready; a transaction completes when valid and ready are high.
// Operation: the list lives in one entry memory indexed by list position
//   (registered read). A command scans positions from the head, reading
//   then comparing each entry; a seen that inserts or a connected that
//   matches then moves entries one place, reading then writing each move,
//   and writes the new entry unless the connected had failed storage.
// Short cases: seen with a bad kind or failed storage and unknown commands
//   skip the scan and go straight to the result. One command at a time.
// Reset: aresetn (sync, active low) empties the list; memory contents are
//   not cleared since only positions below the entry count are ever read.
// Stall: the finished result waits in the m_data register; s_ready returns
//   high as soon as it is loaded, so the next command may start while the
//   receiver stalls. A second result waits in DONE until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module known_network_recency_ranker_top
    import knrr_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    state_t state_reg, state_next;

    logic [1:0]  cmd_reg,   cmd_next;
    entry_t      new_reg,   new_next;
    logic        ok_reg,    ok_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg,   idx_next;
    logic [CW-1:0] dst_reg,   dst_next;
    logic [CW-1:0] end_reg,   end_next;
    logic        fwd_reg,   fwd_next;
    logic        wr_reg,    wr_next;
    out_t        res_reg,   res_next;
    out_t        m_data_reg, m_data_next;
    logic        m_valid_reg, m_valid_next;

    entry_t mem [MAX_ENTRIES];
    entry_t rdata_reg;

    logic          mem_re, mem_we;
    logic [IW-1:0] mem_raddr, mem_waddr;
    entry_t        mem_wdata;

    logic [SSID_BITS-1:0] key;
    logic          hit, decide, found;
    logic [8:0]    pos_wide;
    logic [CW-1:0] eff_count;

    knrr_trim u_trim (
        .raw ({s_data.ssid_word3, s_data.ssid_word2, s_data.ssid_word1, s_data.ssid_word0}),
        .key (key)
    );

    // entry memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        new_reg    <= new_next;
        ok_reg     <= ok_next;
        idx_reg    <= idx_next;
        dst_reg    <= dst_next;
        end_reg    <= end_next;
        fwd_reg    <= fwd_next;
        wr_reg     <= wr_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        new_next     = new_reg;
        ok_next      = ok_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        dst_next     = dst_reg;
        end_next     = end_reg;
        fwd_next     = fwd_reg;
        wr_next      = wr_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = idx_reg[IW-1:0];
        mem_we       = 1'b0;
        mem_waddr    = dst_reg[IW-1:0];
        mem_wdata    = rdata_reg;
        decide       = 1'b0;
        found        = 1'b0;
        pos_wide     = 9'(idx_reg);
        eff_count    = count_reg;

        // seen: stop at first older entry; others: first key/kind match
        if (cmd_reg == CMD_SEEN) begin
            hit = {new_reg.seconds, new_reg.nanos} > {rdata_reg.seconds, rdata_reg.nanos};
        end else begin
            hit = (rdata_reg.kind == new_reg.kind) && (rdata_reg.ssid == new_reg.ssid);
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next  = s_data.command;
                    new_next  = '{ssid: key, kind: s_data.security_type,
                                  seconds: s_data.stored_seconds,
                                  nanos: s_data.stored_nanos};
                    ok_next   = s_data.storage_ok;
                    idx_next  = '0;
                    res_next  = '0;
                    if ((s_data.command == CMD_SEEN &&
                         !(s_data.security_type == KIND_PSK && s_data.storage_ok)) ||
                        (s_data.command != CMD_SEEN && s_data.command != CMD_CONNECTED &&
                         s_data.command != CMD_RANK)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                if (idx_reg == count_reg) begin
                    decide = 1'b1;
                end else begin
                    mem_re     = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (hit) begin
                    decide = 1'b1;
                    found  = 1'b1;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MOVE_RD: begin
                if (dst_reg == end_reg) begin
                    state_next = wr_reg ? ST_WRITE : ST_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = fwd_reg ? IW'(dst_reg + 1'b1) : IW'(dst_reg - 1'b1);
                    state_next = ST_MOVE_WR;
                end
            end
            ST_MOVE_WR: begin
                mem_we     = 1'b1;
                dst_next   = fwd_reg ? dst_reg + 1'b1 : dst_reg - 1'b1;
                state_next = ST_MOVE_RD;
            end
            ST_WRITE: begin
                mem_we     = 1'b1;
                mem_waddr  = end_reg[IW-1:0];
                mem_wdata  = new_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // scan finished at position idx_reg
        if (decide) begin
            state_next = ST_DONE;
            case (cmd_reg)
                CMD_SEEN: begin
                    if (!(count_reg == CW'(MAX_ENTRIES) && !found)) begin
                        if (count_reg == CW'(MAX_ENTRIES)) begin
                            eff_count = CW'(MAX_ENTRIES - 1);
                        end
                        count_next       = eff_count + 1'b1;
                        res_next.success = 1'b1;
                        res_next.evicted = (count_reg == CW'(MAX_ENTRIES));
                        fwd_next   = 1'b0;
                        dst_next   = eff_count;
                        end_next   = idx_reg;
                        wr_next    = 1'b1;
                        state_next = ST_MOVE_RD;
                    end
                end
                CMD_CONNECTED: begin
                    if (found) begin
                        if (ok_reg) begin
                            res_next.success = 1'b1;
                            fwd_next = 1'b0;
                            dst_next = idx_reg;
                            end_next = '0;
                            wr_next  = 1'b1;
                        end else begin
                            fwd_next   = 1'b1;
                            dst_next   = idx_reg;
                            end_next   = count_reg - 1'b1;
                            wr_next    = 1'b0;
                            count_next = count_reg - 1'b1;
                        end
                        state_next = ST_MOVE_RD;
                    end
                end
                default: begin
                    if (found) begin
                        res_next.success       = 1'b1;
                        res_next.rank_modifier = rank_factor(
                            (pos_wide > 9'(TABLE_SIZE - 1)) ? 6'(TABLE_SIZE - 1)
                                                            : pos_wide[5:0]);
                    end
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `KNRR_ASSERT(a_count_bound, count_reg <= CW'(MAX_ENTRIES))
    `KNRR_ASSERT_NXT(a_count_step, 1'b1,
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1) ||
        (count_reg == $past(count_reg) - 1'b1))
    `KNRR_ASSERT_IMP(a_evict_ok, m_valid_reg && m_data_reg.evicted,
        m_data_reg.success && m_data_reg.rank_modifier == 17'd0)
    `KNRR_ASSERT_IMP(a_write_range, mem_we, mem_waddr < IW'(MAX_ENTRIES - 1) ||
        mem_waddr == IW'(MAX_ENTRIES - 1))

endmodule

### dv/tb_known_network_recency_ranker_top.sv
// ----------------------------------------------------------------------------
// tb_known_network_recency_ranker_top
// Self-checking bench for the known-network recency ranker: a directed table
// of commands, then random traffic on a small SSID pool, every result checked
// against the table or an in-bench list model under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_known_network_recency_ranker_top;
    import knrr_pkg::*;

    localparam int DEPTH      = 64;
    localparam int N_RANDOM   = 800;
    localparam int WDOG_LIMIT = 20000;

    // Command 3 has no name in the package; keep it local.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    always #1 aclk = ~aclk;

    known_network_recency_ranker_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // List model: position 0 is the most recent entry, by stored time or by connection.
    // ------------------------------------------------------------------
    entry_t      net_list[DEPTH];
    int          net_count;
    out_t        pending_results[$];
    int          mismatches;
    logic [16:0] factor_tab[64] = '{
        65536, 53232, 47135, 43238, 40438, 38286, 36555, 35120,
        33901, 32846, 31920, 31098, 30360, 29692, 29084, 28526,
        28012, 27536, 27093, 26679, 26291, 25927, 25584, 25259,
        24952, 24660, 24382, 24118, 23865, 23623, 23392, 23170,
        22958, 22753, 22556, 22366, 22183, 22006, 21835, 21670,
        21510, 21355, 21205, 21059, 20918, 20780, 20647, 20517,
        20390, 20267, 20147, 20030, 19916, 19804, 19696, 19590,
        19486, 19384, 19285, 19188, 19093, 19000, 18909, 18820
    };

    // SSID ends at its first zero byte; everything after is cleared.
    function automatic logic [255:0] trim_ssid(in_t t);
        logic [255:0] raw;
        logic [255:0] r;
        bit ended;
        raw = {t.ssid_word3, t.ssid_word2, t.ssid_word1, t.ssid_word0};
        r = '0;
        ended = 0;
        for (int b = 0; b < 32; b++) begin
            if (raw[8*b +: 8] == 8'h00) ended = 1;
            if (!ended) r[8*b +: 8] = raw[8*b +: 8];
        end
        return r;
    endfunction

    function automatic int find_network(logic [255:0] id, logic [1:0] kind);
        for (int i = 0; i < net_count; i++)
            if (net_list[i].kind == kind && net_list[i].ssid == id) return i;
        return -1;
    endfunction

    function automatic void insert_at(int pos, entry_t e);
        for (int i = net_count; i > pos; i--) net_list[i] = net_list[i-1];
        net_list[pos] = e;
        net_count++;
    endfunction

    function automatic out_t rank_update(in_t t);
        out_t   r;
        entry_t e;
        int     pos;
        r = '0;
        e.ssid = trim_ssid(t);
        e.kind = t.security_type;
        e.seconds = t.stored_seconds;
        e.nanos = t.stored_nanos;
        case (t.command)
            CMD_SEEN: begin
                if (t.security_type == KIND_PSK && t.storage_ok) begin
                    // equal times go after existing ones
                    pos = 0;
                    while (pos < net_count && {net_list[pos].seconds, net_list[pos].nanos}
                           >= {e.seconds, e.nanos}) pos++;
                    if (net_count >= DEPTH) begin
                        if (pos < net_count) begin
                            net_count = DEPTH - 1;
                            insert_at(pos, e);
                            r.evicted = 1'b1;
                            r.success = 1'b1;
                        end
                    end else begin
                        insert_at(pos, e);
                        r.success = 1'b1;
                    end
                end
            end
            CMD_CONNECTED: begin
                pos = find_network(e.ssid, e.kind);
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < net_count; i++) net_list[i] = net_list[i+1];
                    net_count--;
                    if (t.storage_ok) begin
                        insert_at(0, e);
                        r.success = 1'b1;
                    end
                end
            end
            CMD_RANK: begin
                pos = find_network(e.ssid, e.kind);
                if (pos >= 0) begin
                    r.success = 1'b1;
                    r.rank_modifier = factor_tab[pos > 63 ? 63 : pos];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    typedef struct {
        in_t  txn;
        bit   has_exp;
        out_t exp;
    } row_t;

    row_t directed_rows[$];

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Pool of 8 short SSIDs so that connected and rank usually hit.
    function automatic in_t pool_txn(logic [1:0] cmd);
        in_t t;
        int  k;
        k = $urandom_range(0, 7);
        t.command = cmd;
        t.ssid_word0 = {56'h0, 8'h41 + 8'(k)};
        if ($urandom_range(0, 3) == 0)
            t.ssid_word0 = {rand64()} & 64'h00ff_ffff_ffff_ff00 | t.ssid_word0;
        t.ssid_word1 = $urandom_range(0, 1) ? rand64() : '0;  // junk after terminator
        t.ssid_word2 = $urandom_range(0, 1) ? rand64() : '0;
        t.ssid_word3 = $urandom_range(0, 1) ? rand64() : '0;
        t.security_type = ($urandom_range(0, 4) == 0) ? 2'($urandom()) : KIND_PSK;
        t.stored_seconds = $urandom_range(0, 3) == 0 ? {$urandom(), 8'($urandom())}
                                                     : 40'($urandom_range(0, 20));
        t.stored_nanos = $urandom_range(0, 3) == 0 ? 30'($urandom_range(0, 999999999))
                                                   : 30'($urandom_range(0, 2));
        t.storage_ok = $urandom_range(0, 7) != 0;
        return t;
    endfunction

    function automatic in_t wild_txn();
        in_t t;
        t.command = 2'($urandom());
        t.ssid_word0 = rand64();
        t.ssid_word1 = rand64();
        t.ssid_word2 = rand64();
        t.ssid_word3 = rand64();
        t.security_type = 2'($urandom());
        t.stored_seconds = {$urandom(), 8'($urandom())};
        t.stored_nanos = 30'($urandom_range(0, 999999999));
        t.storage_ok = 1'($urandom());
        return t;
    endfunction

    function automatic void add_row(in_t t, bit has_exp, out_t exp);
        row_t r;
        r.txn = t;
        r.has_exp = has_exp;
        r.exp = exp;
        directed_rows.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Sender: drive a transaction and wait for acceptance. Valid drops
    // only in idle cycles, so back-to-back transactions keep it high.
    // ------------------------------------------------------------------
    bit quiet_phase;

    task automatic send_txn(in_t t, bit has_exp, out_t exp);
        out_t predicted;
        while (!quiet_phase && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = rank_update(t);
        if (has_exp && predicted != exp)
            $display("note: table row disagrees with prediction exp=%h pred=%h",
                     exp, predicted);
        pending_results.push_back(has_exp ? exp : predicted);
    endtask

    // ------------------------------------------------------------------
    // Receiver with random stalls and one long hold-off so the block
    // backs up and drops s_ready.
    // ------------------------------------------------------------------
    bit hold_off;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && (quiet_phase || $urandom_range(0, 99) >= 33);
        end
    end

    // checking happens at the sampling edge
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result %h", m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.success !== want.success
                    || m_data.rank_modifier !== want.rank_modifier
                    || m_data.evicted !== want.evicted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp s=%0b m=%0d e=%0b got s=%0b m=%0d e=%0b",
                                 want.success, want.rank_modifier, want.evicted,
                                 m_data.success, m_data.rank_modifier, m_data.evicted);
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either side.
    int idle_cycles;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process.
    initial begin
        hold_off = 0;
        wait (directed_rows.size() > 0 && aresetn);
        repeat (3000) @(posedge aclk);
        hold_off = 1;
        repeat (600) @(posedge aclk);
        hold_off = 0;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        in_t  t;
        out_t none;
        out_t e;
        mismatches = 0;
        net_count = 0;
        quiet_phase = 0;
        none = '0;

        // directed table
        t = pool_txn(CMD_RANK);
        t.security_type = KIND_PSK;
        add_row(t, 1, none);                       // rank on an empty list
        t.command = CMD_CONNECTED;
        add_row(t, 1, none);                       // connected, no match
        t = wild_txn();
        t.command = CMD_UNKNOWN;
        add_row(t, 1, none);                       // unknown command
        t = wild_txn();
        t.command = CMD_SEEN;
        t.security_type = 2'd1;
        add_row(t, 1, none);                       // seen, not PSK
        t.security_type = KIND_PSK;
        t.storage_ok = 1'b0;
        add_row(t, 1, none);                       // seen, storage failed
        // extremes of time and SSID, all bits set
        t = wild_txn();
        t.command = CMD_SEEN;
        t.ssid_word0 = '1; t.ssid_word1 = '1; t.ssid_word2 = '1; t.ssid_word3 = '1;
        t.security_type = KIND_PSK;
        t.stored_seconds = '1;
        t.stored_nanos = 30'd999999999;
        t.storage_ok = 1'b1;
        e = none; e.success = 1'b1;
        add_row(t, 1, e);
        t.command = CMD_RANK;
        e.rank_modifier = 17'd65536;
        add_row(t, 1, e);                          // head position
        // zero time, empty SSID
        t = '0;
        t.command = CMD_SEEN;
        t.security_type = KIND_PSK;
        t.storage_ok = 1'b1;
        add_row(t, 0, none);
        t.command = CMD_RANK;
        add_row(t, 0, none);
        // equal time ties go behind, connected moves to head
        t = pool_txn(CMD_SEEN);
        t.security_type = KIND_PSK; t.storage_ok = 1'b1;
        t.stored_seconds = 40'd5; t.stored_nanos = 30'd1;
        add_row(t, 0, none);
        t.ssid_word0 = 64'h42; add_row(t, 0, none);
        t.command = CMD_RANK; add_row(t, 0, none);
        t.command = CMD_CONNECTED; add_row(t, 0, none);
        t.command = CMD_RANK; add_row(t, 0, none);
        t.command = CMD_CONNECTED; t.storage_ok = 1'b0; add_row(t, 0, none);
        t.command = CMD_RANK; add_row(t, 0, none);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_txn(directed_rows[i].txn, directed_rows[i].has_exp, directed_rows[i].exp);

        // Random part: mostly pool traffic; frequent seen commands fill the list
        // past its depth so eviction is hit. A quiet stretch in the middle runs
        // without idling.
        for (int n = 0; n < N_RANDOM; n++) begin
            int pick;
            quiet_phase = (n >= 300 && n < 400);
            pick = $urandom_range(0, 99);
            if (pick < 10) t = wild_txn();
            else if (pick < 55) t = pool_txn(CMD_SEEN);
            else if (pick < 75) t = pool_txn(CMD_CONNECTED);
            else t = pool_txn(CMD_RANK);
            send_txn(t, 0, none);
        end
        s_valid <= 1'b0;
        quiet_phase = 0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### known_network_recency_ranker_top.f
+incdir+rtl
rtl/knrr_pkg.sv
rtl/knrr_trim.sv
rtl/known_network_recency_ranker_top.sv
dv/tb_known_network_recency_ranker_top.sv
